>>> hdl/axapb_pkg.sv
package axapb_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int ADDR_W   = 32;
   localparam int WORD_W   = 32;
   localparam int STRB_W   = 4;
   localparam int PROT_W   = 3;
   localparam int TAG_W    = 5;
   localparam int RESP_W   = 2;
   localparam int RDATA_W  = 64;

   localparam int REQ_TDATA_W = 192;
   localparam int RSP_TDATA_W = 144;

   localparam logic [RESP_W-1:0] RESP_OKAY   = 2'd0;
   localparam logic [RESP_W-1:0] RESP_SLVERR = 2'd2;

   localparam logic [2:0] SIZE_WIDE_MIN = 3'd3;
   localparam logic [ADDR_W-1:0] WORD_STEP = 32'd4;

   typedef enum logic [1:0] {
      KIND_ACCESS    = 2'd0,
      KIND_READ_RSP  = 2'd1,
      KIND_WRITE_RSP = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      MODE_BURST  = 2'd0,
      MODE_WIDE   = 2'd1,
      MODE_NARROW = 2'd2
   } mode_type;

   // one classified request, ready for the sequencer
   typedef struct packed {
      mode_type              mode;
      logic                  is_write;
      logic [ADDR_W-1:0]     addr;
      logic [PROT_W-1:0]     prot;
      logic [TAG_W-1:0]      tag;
      logic                  side;
      logic [WORD_W-1:0]     wdata_first;
      logic [STRB_W-1:0]     strb_first;
      logic [WORD_W-1:0]     wdata_second;
      logic [STRB_W-1:0]     strb_second;
      logic [RDATA_W-1:0]    rdata;
      logic [RESP_W-1:0]     resp;
   } entry_type;

   // one result beat
   typedef struct packed {
      kind_type              kind;
      logic [ADDR_W-1:0]     apb_addr;
      logic                  apb_write;
      logic [WORD_W-1:0]     apb_wdata;
      logic [STRB_W-1:0]     apb_strb;
      logic [PROT_W-1:0]     apb_prot;
      logic [RESP_W-1:0]     resp;
      logic [RDATA_W-1:0]    rdata;
      logic [TAG_W-1:0]      resp_tag;
      logic                  resp_side;
      logic                  last;
   } beat_type;

   // queue handshake between front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

>>> hdl/axapb_front.sv
module axapb_front (
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [axapb_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                 req_tuser,
   input  axapb_pkg::qstat_type                 qstat,
   output logic                                 push,
   output axapb_pkg::entry_type                 entry
);
   import axapb_pkg::*;

   logic [31:0] addr;
   logic [2:0]  size;
   logic [7:0]  burst_len;
   logic [63:0] wdata;
   logic [7:0]  wstrb;
   logic [31:0] rd_first;
   logic [31:0] rd_second;
   logic [1:0]  slave_err;
   logic        is_write;

   assign addr      = req_tdata[31:0];
   assign size      = req_tdata[34:32];
   assign burst_len = req_tdata[42:35];
   assign wdata     = req_tdata[115:52];
   assign wstrb     = req_tdata[123:116];
   assign rd_first  = req_tdata[155:124];
   assign rd_second = req_tdata[187:156];
   assign slave_err = req_tdata[189:188];
   assign is_write  = req_tuser;

   assign req_tready = !qstat.full;
   assign push       = req_tvalid && !qstat.full;

   always_comb begin
      entry              = '0;
      entry.is_write     = is_write;
      entry.addr         = {addr[31:2], 2'b00};
      entry.prot         = req_tdata[45:43];
      entry.tag          = req_tdata[50:46];
      entry.side         = req_tdata[51];
      if (burst_len != 8'd0) begin
         entry.mode  = MODE_BURST;
         entry.resp  = RESP_SLVERR;
         entry.rdata = is_write ? 64'd0 : '1;
      end else if (size >= SIZE_WIDE_MIN) begin
         entry.mode  = MODE_WIDE;
         entry.resp  = slave_err[1] ? RESP_SLVERR : RESP_OKAY;
         entry.rdata = is_write ? 64'd0 : {rd_second, rd_first};
         if (is_write) begin
            entry.wdata_first  = wdata[31:0];
            entry.strb_first   = wstrb[3:0];
            entry.wdata_second = wdata[63:32];
            entry.strb_second  = wstrb[7:4];
         end
      end else begin
         entry.mode  = MODE_NARROW;
         entry.resp  = slave_err[0] ? RESP_SLVERR : RESP_OKAY;
         entry.rdata = is_write ? 64'd0 : {32'd0, rd_first};
         // address bit 2 picks the lane of the 64-bit write bus
         if (is_write) begin
            entry.wdata_first = addr[2] ? wdata[63:32] : wdata[31:0];
            entry.strb_first  = addr[2] ? wstrb[7:4] : wstrb[3:0];
         end
      end
   end

endmodule

>>> hdl/axapb_queue.sv
module axapb_queue #(
   parameter int DEPTH = axapb_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  axapb_pkg::entry_type  push_entry,
   input  logic                  pop,
   output axapb_pkg::entry_type  head,
   output axapb_pkg::qstat_type  qstat
);
   import axapb_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type         slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) next_ptr = '0;
      else                        next_ptr = p + 1'b1;
   endfunction

   assign qstat.full  = (count_ff == CNT_W'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head        = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push)
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !pop)
      else $error("pop from empty queue");

endmodule

>>> hdl/axapb_back.sv
module axapb_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  axapb_pkg::entry_type                 head,
   input  axapb_pkg::qstat_type                 qstat,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [axapb_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast
);
   import axapb_pkg::*;

   typedef enum logic [1:0] {
      STEP_FIRST  = 2'd0,
      STEP_SECOND = 2'd1,
      STEP_RESP   = 2'd2
   } step_type;

   step_type  step_ff, step_in;
   logic      out_valid_ff, out_valid_in;
   beat_type  out_ff, out_in;
   logic      head_valid;
   logic      out_free;
   logic      fire;
   logic      is_resp;

   assign head_valid = !qstat.empty;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign fire       = head_valid && out_free;
   assign is_resp    = (step_ff == STEP_RESP) || (head.mode == MODE_BURST);
   assign pop        = fire && is_resp;

   always_comb begin
      out_in = '0;
      if (is_resp) begin
         out_in.kind      = head.is_write ? KIND_WRITE_RSP : KIND_READ_RSP;
         out_in.resp      = head.resp;
         out_in.rdata     = head.rdata;
         out_in.resp_tag  = head.tag;
         out_in.resp_side = head.side;
         out_in.last      = 1'b1;
      end else begin
         out_in.kind      = KIND_ACCESS;
         out_in.apb_write = head.is_write;
         out_in.apb_prot  = head.prot;
         if (step_ff == STEP_SECOND) begin
            // second word wraps at the top of the address space
            out_in.apb_addr  = head.addr + WORD_STEP;
            out_in.apb_wdata = head.wdata_second;
            out_in.apb_strb  = head.strb_second;
         end else begin
            out_in.apb_addr  = head.addr;
            out_in.apb_wdata = head.wdata_first;
            out_in.apb_strb  = head.strb_first;
         end
      end
   end

   always_comb begin
      step_in = step_ff;
      if (fire) begin
         case (step_ff)
            STEP_FIRST: begin
               if (is_resp)                    step_in = STEP_FIRST;
               else if (head.mode == MODE_WIDE) step_in = STEP_SECOND;
               else                            step_in = STEP_RESP;
            end
            STEP_SECOND: step_in = STEP_RESP;
            STEP_RESP:   step_in = STEP_FIRST;
            default:     step_in = STEP_FIRST;
         endcase
      end
      if (fire)            out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
      else                 out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
      if (fire) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {out_ff.resp_side, out_ff.resp_tag, out_ff.rdata, out_ff.resp,
                        out_ff.apb_prot, out_ff.apb_strb, out_ff.apb_wdata,
                        out_ff.apb_write, out_ff.apb_addr};

   a_head_held: assert property (@(posedge clock) disable iff (reset)
      step_ff != STEP_FIRST |-> head_valid)
      else $error("request left queue in mid sequence");
   a_second_wide: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_SECOND |-> head.mode == MODE_WIDE)
      else $error("second access on a non-wide request");
   a_access_advances: assert property (@(posedge clock) disable iff (reset)
      fire && !is_resp |=> step_ff != STEP_FIRST)
      else $error("access beat did not advance the sequence");
   a_access_not_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.kind == KIND_ACCESS |-> !out_ff.last)
      else $error("apb access beat flagged last");

endmodule

>>> hdl/axi4_to_apb_bridge_top.sv
// axi4 to apb bridge
// req channel: one single-beat axi read or write request per beat, together
//    with the words and error flags the apb slave returns for it.
// rsp channel: the apb access beats the request causes (tuser kind access),
//    then the axi response beat with tlast high. a wide request (size 3 or
//    more) gives two accesses and a response, a narrow one an access and a
//    response, a burst request only an slverr response.
// with the queue empty and the output register free, a taken request beat is
//    first written into the queue, then its first beat into the output register.
// throughput: one rsp beat per cycle while the receiver does not stall, from
//    the sequencer's single output register; three beats per wide request,
//    two per narrow, one per burst; a QUEUE_DEPTH entry queue holds requests.
// reset empties the queue and the output register; no beat is pending after.
// when the receiver stalls the output beat holds, the sequencer waits, and
//    req_tready drops once the queue is full.
module axi4_to_apb_bridge_top #(
   parameter int QUEUE_DEPTH = axapb_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // addr, size, burst_len, prot, req_tag, req_side, wdata, wstrb,
   // slave_rdata_first, slave_rdata_second, slave_err, zero pad
   input  logic [axapb_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // cmd
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // apb_addr, apb_write, apb_wdata, apb_strb, apb_prot, resp, rdata,
   // resp_tag, resp_side
   output logic [axapb_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // kind
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast
);
   import axapb_pkg::*;

   entry_type  push_entry;
   entry_type  head;
   qstat_type  qstat;
   logic       push;
   logic       pop;

   axapb_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .qstat      (qstat),
      .push       (push),
      .entry      (push_entry)
   );

   axapb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   axapb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> sim/axi4_to_apb_bridge_top_test.sv
module axi4_to_apb_bridge_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import axapb_pkg::*;

   localparam int CYCLE_LIMIT = 50000;
   localparam int DRAIN_CYCLES = 10;
   localparam logic REQ_READ = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // one request as it travels on the req channel
   typedef struct packed {
      logic                 cmd;
      logic [ADDR_W-1:0]    addr;
      logic [2:0]           size;
      logic [7:0]           burst_len;
      logic [PROT_W-1:0]    prot;
      logic [TAG_W-1:0]     tag;
      logic                 side;
      logic [63:0]          wdata;
      logic [7:0]           wstrb;
      logic [WORD_W-1:0]    rd_first;
      logic [WORD_W-1:0]    rd_second;
      logic [1:0]           slave_err;
   } axi_req_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [1:0]              rsp_tuser;
   logic                    rsp_tlast;

   beat_type                expected_beats[$];
   int                      mismatch_count;
   int                      cycle_count;
   logic                    idle_enable;

   axi4_to_apb_bridge_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // receiver stalls now and then
   always @(negedge clock) begin
      if (!reset)
         rsp_tready = !(idle_enable && ($urandom_range(99) < 10));
   end

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h", field, got, want);
      mismatch_count++;
   endtask

   // expected beats of one request, pushed in output order
   function automatic void predict_beats(input axi_req_type r);
      beat_type          b;
      logic [ADDR_W-1:0] a;
      logic              wide;
      logic              erred;
      a = {r.addr[ADDR_W-1:2], 2'b00};
      wide = (r.size >= SIZE_WIDE_MIN);
      if (r.burst_len == 8'd0) begin
         b = '0;
         b.kind = KIND_ACCESS;
         b.apb_addr = a;
         b.apb_write = r.cmd;
         b.apb_prot = r.prot;
         if (r.cmd == REQ_WRITE) begin
            if (!wide && a[2]) begin
               b.apb_wdata = r.wdata[63:32];
               b.apb_strb = r.wstrb[7:4];
            end else begin
               b.apb_wdata = r.wdata[31:0];
               b.apb_strb = r.wstrb[3:0];
            end
         end
         expected_beats.push_back(b);
         if (wide) begin
            b.apb_addr = a + WORD_STEP;
            if (r.cmd == REQ_WRITE) begin
               b.apb_wdata = r.wdata[63:32];
               b.apb_strb = r.wstrb[7:4];
            end
            expected_beats.push_back(b);
         end
      end
      b = '0;
      b.kind = (r.cmd == REQ_WRITE) ? KIND_WRITE_RSP : KIND_READ_RSP;
      b.resp_tag = r.tag;
      b.resp_side = r.side;
      b.last = 1'b1;
      if (r.burst_len != 8'd0) begin
         b.resp = RESP_SLVERR;
         if (r.cmd == REQ_READ) b.rdata = '1;
      end else begin
         erred = wide ? r.slave_err[1] : r.slave_err[0];
         b.resp = erred ? RESP_SLVERR : RESP_OKAY;
         if (r.cmd == REQ_READ)
            b.rdata = wide ? {r.rd_second, r.rd_first} : {32'd0, r.rd_first};
      end
      expected_beats.push_back(b);
   endfunction

   function automatic axi_req_type make_req(input logic cmd, input logic [31:0] addr,
                                            input logic [2:0] size,
                                            input logic [7:0] burst_len,
                                            input logic [1:0] slave_err);
      axi_req_type r;
      r.cmd = cmd;
      r.addr = addr;
      r.size = size;
      r.burst_len = burst_len;
      r.prot = PROT_W'($urandom_range(7));
      r.tag = TAG_W'($urandom_range(31));
      r.side = 1'($urandom_range(1));
      r.wdata = {$urandom, $urandom};
      r.wstrb = 8'($urandom_range(255));
      r.rd_first = $urandom;
      r.rd_second = $urandom;
      r.slave_err = slave_err;
      return r;
   endfunction

   function automatic axi_req_type random_req();
      logic [31:0] addr;
      logic [7:0]  blen;
      addr = $urandom;
      // now and then land next to the top of the address space
      if ($urandom_range(9) == 0) addr = 32'hFFFF_FFF8 | $urandom_range(7);
      blen = 8'd0;
      if ($urandom_range(99) < 15) blen = 8'($urandom_range(255, 1));
      return make_req(1'($urandom_range(1)), addr, 3'($urandom_range(7)), blen,
                      2'($urandom_range(3)));
   endfunction

   task automatic send_request(input axi_req_type r);
      @(negedge clock);
      while (idle_enable && ($urandom_range(99) < 10)) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      predict_beats(r);
      req_tdata = {2'b00, r.slave_err, r.rd_second, r.rd_first, r.wstrb, r.wdata,
                   r.side, r.tag, r.prot, r.burst_len, r.size, r.addr};
      req_tuser = r.cmd;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata[63:0], '0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("kind", rsp_tuser, want.kind);
            if (rsp_tdata[31:0] !== want.apb_addr)
               report_mismatch("apb_addr", rsp_tdata[31:0], want.apb_addr);
            if (rsp_tdata[32] !== want.apb_write)
               report_mismatch("apb_write", rsp_tdata[32], want.apb_write);
            if (rsp_tdata[64:33] !== want.apb_wdata)
               report_mismatch("apb_wdata", rsp_tdata[64:33], want.apb_wdata);
            if (rsp_tdata[68:65] !== want.apb_strb)
               report_mismatch("apb_strb", rsp_tdata[68:65], want.apb_strb);
            if (rsp_tdata[71:69] !== want.apb_prot)
               report_mismatch("apb_prot", rsp_tdata[71:69], want.apb_prot);
            if (rsp_tdata[73:72] !== want.resp)
               report_mismatch("resp", rsp_tdata[73:72], want.resp);
            if (rsp_tdata[137:74] !== want.rdata)
               report_mismatch("rdata", rsp_tdata[137:74], want.rdata);
            if (rsp_tdata[142:138] !== want.resp_tag)
               report_mismatch("resp_tag", rsp_tdata[142:138], want.resp_tag);
            if (rsp_tdata[143] !== want.resp_side)
               report_mismatch("resp_side", rsp_tdata[143], want.resp_side);
            if (rsp_tlast !== want.last)
               report_mismatch("last", rsp_tlast, want.last);
         end
      end
   end

   task automatic test_narrow_access();
      axi_req_type r;
      r = make_req(REQ_READ, 32'h0000_0000, 3'd0, 8'd0, 2'd0);
      r.prot = '0;
      r.tag = '0;
      r.side = 1'b0;
      send_request(r);
      send_request(make_req(REQ_READ, 32'hFFFF_FFFF, 3'd2, 8'd0, 2'd1));
      // second error bit is ignored on a narrow request
      send_request(make_req(REQ_READ, 32'h1234_5678, 3'd2, 8'd0, 2'd2));
      r = make_req(REQ_WRITE, 32'h0000_0004, 3'd2, 8'd0, 2'd0);
      r.wdata = '1;
      r.wstrb = 8'hFF;
      r.prot = '1;
      r.tag = '1;
      r.side = 1'b1;
      send_request(r);
      r = make_req(REQ_WRITE, 32'h0000_0008, 3'd1, 8'd0, 2'd0);
      r.wstrb = 8'h0F;
      send_request(r);
      r = make_req(REQ_WRITE, 32'hFFFF_FFFB, 3'd0, 8'd0, 2'd3);
      r.wdata = '0;
      r.wstrb = 8'h00;
      send_request(r);
   endtask

   task automatic test_wide_access();
      axi_req_type r;
      send_request(make_req(REQ_READ, 32'h0000_0000, 3'd3, 8'd0, 2'd0));
      // second word address wraps past the top
      send_request(make_req(REQ_READ, 32'hFFFF_FFFC, 3'd7, 8'd0, 2'd2));
      send_request(make_req(REQ_READ, 32'h8000_0006, 3'd6, 8'd0, 2'd1));
      send_request(make_req(REQ_WRITE, 32'hFFFF_FFFF, 3'd3, 8'd0, 2'd1));
      r = make_req(REQ_WRITE, 32'h0000_0010, 3'd4, 8'd0, 2'd3);
      r.wdata = '0;
      r.wstrb = 8'h00;
      send_request(r);
      r = make_req(REQ_WRITE, 32'h5555_5554, 3'd5, 8'd0, 2'd2);
      r.wdata = '1;
      r.wstrb = 8'hF0;
      send_request(r);
   endtask

   task automatic test_burst_reject();
      send_request(make_req(REQ_READ, $urandom, 3'd2, 8'd1, 2'd0));
      send_request(make_req(REQ_WRITE, $urandom, 3'd3, 8'd255, 2'd0));
      send_request(make_req(REQ_READ, 32'hFFFF_FFFC, 3'd3, 8'd128, 2'd3));
      send_request(make_req(REQ_WRITE, 32'h0000_0000, 3'd0, 8'd1, 2'd3));
   endtask

   task automatic test_random_traffic();
      repeat (64) send_request(random_req());
   endtask

   task automatic test_streaming();
      idle_enable = 1'b0;
      repeat (40) send_request(random_req());
      idle_enable = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      idle_enable = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_narrow_access();
      test_wide_access();
      test_burst_reject();
      test_random_traffic();
      test_streaming();

      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
